// ----- src/sfts_pkg.sv -----
// sfts_pkg: shared types, codes and widths for the sprite frame time selector
// no dependencies; imported by sfts_mod_unit, sfts_seq and the top level

package sfts_pkg;

  // default table depth
  localparam int MAX_FRAMES_DEF = 256;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // field widths
  localparam int SLOT_W  = 8;
  localparam int DUR_W   = 16;
  localparam int CNT_W   = 9;
  localparam int QTIME_W = 32;
  localparam int TIME_W  = QTIME_W - 1;  // time after clamping negatives to zero
  localparam int ACC_W   = 26;           // 510 frames of 65535 ms fit here

  typedef enum logic {
    ACT_LOAD,
    ACT_QUERY
  } action_e;

  typedef enum logic [1:0] {
    MODE_LOOP,
    MODE_ONCE,
    MODE_REVERSE,
    MODE_PINGPONG
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_FRAME,
    REG_FRAME_COUNT,
    REG_PLAYBACK_MODE,
    REG_LOOP_ENABLE,
    REG_FRAMES_IN_ASSET
  } reg_e;

  typedef struct packed {
    logic [SLOT_W-1:0] first_frame;
    logic [CNT_W-1:0]  frame_count;
    mode_e             mode;
    logic              loop_en;
    logic [CNT_W-1:0]  frames_in_asset;
  } clip_cfg_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [ACC_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] rem;
  } mod_rsp_t;

endpackage

// ----- src/sfts_dur_mem.sv -----
// sfts_dur_mem: frame duration table, one write and one registered read port
// no dependencies

module sfts_dur_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/sfts_mod_unit.sv -----
// sfts_mod_unit: restoring remainder unit, one dividend bit per cycle
// depends on sfts_pkg

module sfts_mod_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfts_pkg::mod_req_t  req_i,
  output sfts_pkg::mod_rsp_t  rsp_o
);
  import sfts_pkg::*;

  localparam int STEP_W = $clog2(TIME_W + 1);

  logic              active_q, active_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [TIME_W-1:0] dvd_q, dvd_d;
  logic [ACC_W-1:0]  div_q, div_d;
  logic [ACC_W-1:0]  rem_q, rem_d;
  logic [ACC_W:0]    shifted;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    step_d   = step_q;
    dvd_d    = dvd_q;
    div_d    = div_q;
    rem_d    = rem_q;
    shifted  = {rem_q, dvd_q[TIME_W-1]};
    if (req_i.start) begin
      active_d = 1'b1;
      step_d   = STEP_W'(TIME_W);
      dvd_d    = req_i.dividend;
      div_d    = req_i.divisor;
      rem_d    = '0;
    end else if (active_q) begin
      if (shifted >= {1'b0, div_q}) begin
        rem_d = ACC_W'(shifted - {1'b0, div_q});
      end else begin
        rem_d = ACC_W'(shifted);
      end
      dvd_d  = {dvd_q[TIME_W-2:0], 1'b0};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- src/sfts_seq.sv -----
// sfts_seq: query sequencer, walks the clip through the table read port twice
// depends on sfts_pkg; drives sfts_mod_unit and reads sfts_dur_mem

module sfts_seq #(
  parameter int MAX_FRAMES = sfts_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          query_i,
  input  logic [sfts_pkg::QTIME_W-1:0]  query_time_i,
  input  sfts_pkg::clip_cfg_t           cfg_i,
  output logic                          busy_o,
  output logic                          rd_en_o,
  output logic [sfts_pkg::SLOT_W-1:0]   rd_idx_o,
  input  logic [sfts_pkg::DUR_W-1:0]    rd_data_i,
  output sfts_pkg::mod_req_t            mod_req_o,
  input  sfts_pkg::mod_rsp_t            mod_rsp_i,
  output logic                          result_valid_o,
  output logic [sfts_pkg::SLOT_W-1:0]   frame_index_o,
  output logic                          frame_valid_o
);
  import sfts_pkg::*;

  localparam int LIM_CAP = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_FIT,
    S_MOD,
    S_SCAN
  } state_e;

  function automatic logic [CNT_W-1:0] seq_offset(input logic [CNT_W-1:0] pos,
                                                  input logic [CNT_W-1:0] n,
                                                  input mode_e mode);
    logic [CNT_W:0]   period;
    logic [CNT_W-1:0] off;
    period = {n, 1'b0} - (CNT_W+1)'(2);
    unique case (mode)
      MODE_REVERSE: off = n - CNT_W'(1) - pos;
      MODE_PINGPONG: begin
        if (pos < n) begin
          off = pos;
        end else begin
          off = CNT_W'(period - {1'b0, pos});
        end
      end
      default: off = pos;
    endcase
    return off;
  endfunction

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_last_q, rd_last_d;
  logic [SLOT_W-1:0] rd_idx_q, rd_idx_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [ACC_W-1:0]  tsel_q, tsel_d;
  logic              res_q, res_d;
  logic              fvalid_q, fvalid_d;
  logic [SLOT_W-1:0] fidx_q, fidx_d;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  seq_len;
  logic [CNT_W:0]    len2;
  logic              clip_bad;
  logic              issue;
  logic [CNT_W-1:0]  offset;
  logic [SLOT_W-1:0] idx;
  logic [ACC_W-1:0]  dur;
  logic [ACC_W-1:0]  ahead;
  logic              wrap;

  always_comb begin
    lim = (cfg_i.frames_in_asset > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP)
                                                    : cfg_i.frames_in_asset;
    len2 = {cfg_i.frame_count, 1'b0} - (CNT_W+1)'(2);
    if (cfg_i.mode == MODE_PINGPONG && cfg_i.frame_count > CNT_W'(1)) begin
      seq_len = CNT_W'(len2);
    end else begin
      seq_len = cfg_i.frame_count;
    end
    // every sequence visits offsets 0..n-1, so the last clip frame decides
    clip_bad = (cfg_i.frame_count == '0) ||
               (({1'b0, cfg_i.first_frame} + {1'b0, cfg_i.frame_count}) >
                {1'b0, lim});
    wrap   = cfg_i.loop_en && (cfg_i.mode != MODE_ONCE);
    offset = seq_offset(iss_q, cfg_i.frame_count, cfg_i.mode);
    idx    = SLOT_W'({1'b0, cfg_i.first_frame} + offset);
    issue  = (state_q == S_SUM || state_q == S_SCAN) && (iss_q < seq_len);
    dur    = (rd_data_i == '0) ? ACC_W'(1) : ACC_W'(rd_data_i);
    ahead  = acc_q + dur;
  end

  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    rd_vld_d  = issue;
    rd_last_d = (iss_q == seq_len - CNT_W'(1));
    rd_idx_d  = idx;
    acc_d     = acc_q;
    time_d    = time_q;
    tsel_d    = tsel_q;
    res_d     = 1'b0;
    fvalid_d  = fvalid_q;
    fidx_d    = fidx_q;
    mod_req_o.start    = 1'b0;
    mod_req_o.dividend = time_q;
    mod_req_o.divisor  = acc_q;
    if (issue) begin
      iss_d = iss_q + CNT_W'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i && query_i) begin
          time_d = query_time_i[QTIME_W-1] ? '0 : query_time_i[TIME_W-1:0];
          if (clip_bad) begin
            res_d    = 1'b1;
            fvalid_d = 1'b0;
            fidx_d   = '0;
          end else begin
            state_d = S_SUM;
            iss_d   = '0;
            acc_d   = '0;
          end
        end
      end
      S_SUM: begin
        if (rd_vld_q) begin
          acc_d = ahead;
          if (rd_last_q) begin
            state_d = S_FIT;
          end
        end
      end
      S_FIT: begin
        // acc_q holds the sequence length in ms here
        if (wrap) begin
          mod_req_o.start = 1'b1;
          state_d = S_MOD;
        end else begin
          if (time_q > TIME_W'(acc_q - ACC_W'(1))) begin
            tsel_d = acc_q - ACC_W'(1);
          end else begin
            tsel_d = ACC_W'(time_q);
          end
          state_d = S_SCAN;
          iss_d   = '0;
          acc_d   = '0;
        end
      end
      S_MOD: begin
        if (mod_rsp_i.done) begin
          tsel_d  = mod_rsp_i.rem;
          state_d = S_SCAN;
          iss_d   = '0;
          acc_d   = '0;
        end
      end
      S_SCAN: begin
        if (rd_vld_q) begin
          if ((tsel_q < ahead) || rd_last_q) begin
            res_d    = 1'b1;
            fvalid_d = 1'b1;
            fidx_d   = rd_idx_q;
            state_d  = S_IDLE;
          end else begin
            acc_d = ahead;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      rd_idx_q  <= '0;
      acc_q     <= '0;
      time_q    <= '0;
      tsel_q    <= '0;
      res_q     <= 1'b0;
      fvalid_q  <= 1'b0;
      fidx_q    <= '0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
      rd_idx_q  <= rd_idx_d;
      acc_q     <= acc_d;
      time_q    <= time_d;
      tsel_q    <= tsel_d;
      res_q     <= res_d;
      fvalid_q  <= fvalid_d;
      fidx_q    <= fidx_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign rd_en_o        = issue;
  assign rd_idx_o       = idx;
  assign result_valid_o = res_q;
  assign frame_valid_o  = res_q & fvalid_q;
  assign frame_index_o  = (res_q & fvalid_q) ? fidx_q : '0;

endmodule

// ----- src/sprite_frame_time_selector.sv -----
// sprite_frame_time_selector: top level, configuration registers and wiring
// depends on sfts_pkg, sfts_dur_mem, sfts_mod_unit and sfts_seq

// A load transfer (action 0) writes one duration into the table in the cycle
// it is taken; slots at or beyond MAX_FRAMES are dropped. A query transfer
// (action 1) answers with a one-cycle result_valid_o strobe. For an empty or
// out-of-range clip the answer comes the cycle after the transfer and busy
// stays low. Otherwise the query raises busy, and the table's single read
// port is walked along the sequence (the frame count long, or 2n-2 in
// ping-pong) once to sum the durations and once to find the frame; when the
// time wraps, the remainder comes from a unit that retires one time bit per
// cycle. busy falls in the cycle the strobe is shown. Results cannot be
// held off, so take each one when it is strobed.

module sprite_frame_time_selector #(
  parameter int MAX_FRAMES = sfts_pkg::MAX_FRAMES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             action_i,
  input  logic [sfts_pkg::SLOT_W-1:0]      frame_slot_i,
  input  logic [sfts_pkg::DUR_W-1:0]       frame_duration_i,
  input  logic signed [sfts_pkg::QTIME_W-1:0] query_time_i,
  output logic                             result_valid_o,
  output logic [sfts_pkg::SLOT_W-1:0]      frame_index_o,
  output logic                             frame_valid_o,
  input  logic                             cfg_we_i,
  input  logic [sfts_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfts_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import sfts_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);

  clip_cfg_t         cfg_q;
  logic              take;
  logic              load_we;
  logic              seq_busy;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_idx;
  logic [DUR_W-1:0]  rd_data;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_frame     <= '0;
      cfg_q.frame_count     <= '0;
      cfg_q.mode            <= MODE_LOOP;
      cfg_q.loop_en         <= 1'b1;
      cfg_q.frames_in_asset <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIRST_FRAME:     cfg_q.first_frame     <= cfg_wdata_i[SLOT_W-1:0];
        REG_FRAME_COUNT:     cfg_q.frame_count     <= cfg_wdata_i[CNT_W-1:0];
        REG_PLAYBACK_MODE:   cfg_q.mode            <= mode_e'(cfg_wdata_i[1:0]);
        REG_LOOP_ENABLE:     cfg_q.loop_en         <= cfg_wdata_i[0];
        REG_FRAMES_IN_ASSET: cfg_q.frames_in_asset <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign take    = start && !seq_busy;
  assign load_we = take && (action_i == ACT_LOAD) && (int'(frame_slot_i) < MAX_FRAMES);

  sfts_dur_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW),
    .DW    (DUR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(frame_slot_i)),
    .wdata_i (frame_duration_i),
    .re_i    (rd_en),
    .raddr_i (AW'(rd_idx)),
    .rdata_o (rd_data)
  );

  sfts_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  sfts_seq #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (take),
    .query_i        (action_i == ACT_QUERY),
    .query_time_i   (query_time_i),
    .cfg_i          (cfg_q),
    .busy_o         (seq_busy),
    .rd_en_o        (rd_en),
    .rd_idx_o       (rd_idx),
    .rd_data_i      (rd_data),
    .mod_req_o      (mod_req),
    .mod_rsp_i      (mod_rsp),
    .result_valid_o (result_valid_o),
    .frame_index_o  (frame_index_o),
    .frame_valid_o  (frame_valid_o)
  );

  assign busy = seq_busy;

endmodule

// ----- src/sfts_check.sv -----
// sfts_check: port-level assertions for sprite_frame_time_selector
// bound to the top level below; no other dependencies

module sfts_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        action_i,
  input logic        result_valid_o,
  input logic [7:0]  frame_index_o,
  input logic        frame_valid_o
);

  // a result is never shown while a query is still in work
  a_no_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // busy only rises after a query transfer
  a_busy_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && action_i))
    else $error("busy rose without a query transfer");

  // a query that ends always shows its result
  a_busy_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("query finished without a result");

  // a load transfer causes no result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !action_i) |=> !result_valid_o)
    else $error("result after a load transfer");

  // an invalid answer carries index zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!frame_valid_o) |-> (frame_index_o == 8'd0))
    else $error("nonzero index with invalid frame");

endmodule

bind sprite_frame_time_selector sfts_check u_sfts_check (.*);
